// File: sv/numeric_literal_parser_core_defines.svh
// ----------------------------------------------------------------------------
// numeric literal parser assertion macros
// concurrent checks sampled on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_PARSER_CORE_DEFINES_SVH
`define NUMERIC_LITERAL_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define NLP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// shared types, character codes and digit helpers of the numeric literal parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlp_pkg;

	localparam int unsigned ACC_WIDTH_DEF = 64;
	localparam int unsigned EXP_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		PH_START,
		PH_ZERO,
		PH_INT,
		PH_FRAC,
		PH_EXP_SIGN,
		PH_EXP
	} phase_t;

	typedef enum logic [1:0] {
		RX_BIN,
		RX_OCT,
		RX_DEC,
		RX_HEX
	} radix_t;

	typedef enum logic [1:0] {
		KIND_INT,
		KIND_FRAC,
		KIND_EXP
	} kind_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_UP_P  = 8'h50;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam logic [4:0] NO_DIGIT = 5'd16;

	typedef struct packed {
		phase_t phase;
		radix_t radix;
		logic   octal_bad;
		logic   exp_minus;
		logic   bad_char;
	} ctl_t;

	localparam ctl_t CTL_RESET = '{
		phase:     PH_START,
		radix:     RX_DEC,
		octal_bad: 1'b0,
		exp_minus: 1'b0,
		bad_char:  1'b0
	};

	function automatic logic [7:0] fold_case(logic [7:0] c);
		if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
			return c - CASE_GAP;
		end
		return c;
	endfunction

	function automatic logic [4:0] digit_of(logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
			return v[4:0];
		end
		if (c >= CH_UP_A && c <= CH_UP_F) begin
			v = c - CH_UP_A + 8'd10;
			return v[4:0];
		end
		return NO_DIGIT;
	endfunction

	function automatic logic [4:0] radix_value(radix_t r);
		logic [4:0] v;
		unique case (r)
			RX_BIN: v = 5'd2;
			RX_OCT: v = 5'd8;
			RX_DEC: v = 5'd10;
			RX_HEX: v = 5'd16;
			default: v = 5'd10;
		endcase
		return v;
	endfunction

endpackage

// File: sv/nlp_if.sv
// ----------------------------------------------------------------------------
// nlp_if
// valid/ready channels: literal characters in, parse results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

interface nlp_out_if #(
	parameter int unsigned ACC_WIDTH = nlp_pkg::ACC_WIDTH_DEF,
	parameter int unsigned EXP_WIDTH = nlp_pkg::EXP_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           kind;
	logic [1:0]           radix_code;
	logic [ACC_WIDTH-1:0] numerator;
	logic [ACC_WIDTH-1:0] denominator;
	logic [EXP_WIDTH-1:0] exponent;
	logic                 exponent_base_two;
	logic                 exponent_negative;
	logic                 error;

	modport source (
		output valid, output kind, output radix_code, output numerator,
		output denominator, output exponent, output exponent_base_two,
		output exponent_negative, output error, input ready
	);
	modport sink (
		input valid, input kind, input radix_code, input numerator,
		input denominator, input exponent, input exponent_base_two,
		input exponent_negative, input error, output ready
	);
endinterface

// File: sv/nlp_in_reg.sv
// ----------------------------------------------------------------------------
// nlp_in_reg
// input register for one character request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	nlp_in_if.sink     chars,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] ch_s1,
	output logic       last_s1
);
	logic take;

	assign chars.ready = !valid_s1 || advance;
	assign take        = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end
endmodule

// File: sv/nlp_step.sv
// ----------------------------------------------------------------------------
// nlp_step
// one character of parse: next parser state and the result fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_step #(
	parameter int unsigned ACC_WIDTH = nlp_pkg::ACC_WIDTH_DEF,
	parameter int unsigned EXP_WIDTH = nlp_pkg::EXP_WIDTH_DEF
) (
	input  logic [7:0]           ch,
	input  logic                 last,
	input  nlp_pkg::ctl_t        cur_ctl,
	input  logic [ACC_WIDTH-1:0] cur_main,
	input  logic [ACC_WIDTH-1:0] cur_alt,
	input  logic [ACC_WIDTH-1:0] cur_scale,
	input  logic [EXP_WIDTH-1:0] cur_exp,
	output nlp_pkg::ctl_t        nxt_ctl,
	output logic [ACC_WIDTH-1:0] nxt_main,
	output logic [ACC_WIDTH-1:0] nxt_alt,
	output logic [ACC_WIDTH-1:0] nxt_scale,
	output logic [EXP_WIDTH-1:0] nxt_exp,
	output logic [1:0]           kind,
	output logic [1:0]           radix_code,
	output logic [ACC_WIDTH-1:0] numerator,
	output logic [ACC_WIDTH-1:0] denominator,
	output logic [EXP_WIDTH-1:0] exponent,
	output logic                 exponent_base_two,
	output logic                 exponent_negative,
	output logic                 error
);
	import nlp_pkg::*;

	localparam logic [ACC_WIDTH-1:0] ACC_ONE = {{(ACC_WIDTH-1){1'b0}}, 1'b1};

	// shift-and-add product by the radix
	function automatic logic [ACC_WIDTH-1:0] mul_radix(logic [ACC_WIDTH-1:0] x, radix_t r);
		logic [ACC_WIDTH-1:0] p;
		unique case (r)
			RX_BIN: p = x << 1;
			RX_OCT: p = x << 3;
			RX_DEC: p = (x << 3) + (x << 1);
			RX_HEX: p = x << 4;
			default: p = x;
		endcase
		return p;
	endfunction

	function automatic logic [ACC_WIDTH-1:0] acc_digit(logic [4:0] d);
		return {{(ACC_WIDTH-4){1'b0}}, d[3:0]};
	endfunction

	logic [7:0]           c;
	logic [4:0]           d;
	logic                 quote;
	logic                 do_int;
	radix_t               int_rx;
	logic [7:0]           int_marker;
	logic [7:0]           cur_marker;
	ctl_t                 n;
	logic [ACC_WIDTH-1:0] main_n;
	logic [ACC_WIDTH-1:0] alt_n;
	logic [ACC_WIDTH-1:0] scale_n;
	logic [EXP_WIDTH-1:0] exp_n;
	logic                 is_exp;

	always_comb begin
		c          = fold_case(ch);
		d          = digit_of(c);
		quote      = (c == CH_QUOTE);
		n          = cur_ctl;
		main_n     = cur_main;
		alt_n      = cur_alt;
		scale_n    = cur_scale;
		exp_n      = cur_exp;
		do_int     = 1'b0;
		int_rx     = cur_ctl.radix;
		cur_marker = (cur_ctl.radix == RX_HEX) ? CH_UP_P : CH_UP_E;

		unique case (cur_ctl.phase)
			PH_ZERO: begin
				n.phase = PH_INT;
				if (c == CH_UP_X) begin
					n.radix = RX_HEX;
				end else if (c == CH_UP_B) begin
					n.radix = RX_BIN;
				end else begin
					n.radix = RX_OCT;
					int_rx  = RX_OCT;
					do_int  = 1'b1;
				end
			end
			PH_INT: begin
				do_int = 1'b1;
			end
			PH_FRAC: begin
				if (!quote) begin
					if (c == cur_marker) begin
						n.phase = PH_EXP_SIGN;
					end else if (d < radix_value(cur_ctl.radix)) begin
						main_n  = mul_radix(cur_main, cur_ctl.radix) + acc_digit(d);
						scale_n = mul_radix(cur_scale, cur_ctl.radix);
					end else begin
						n.bad_char = 1'b1;
					end
				end
			end
			PH_EXP_SIGN, PH_EXP: begin
				if (!quote) begin
					if (cur_ctl.phase == PH_EXP_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
						n.exp_minus = (c == CH_MINUS);
						n.phase     = PH_EXP;
					end else if (d < 5'd10) begin
						exp_n   = (cur_exp << 3) + (cur_exp << 1)
							+ {{(EXP_WIDTH-4){1'b0}}, d[3:0]};
						n.phase = PH_EXP;
					end else begin
						n.bad_char = 1'b1;
					end
				end
			end
			default: begin
				if (c == CH_ZERO) begin
					n.radix = RX_OCT;
					n.phase = PH_ZERO;
				end else begin
					n.radix = RX_DEC;
					n.phase = PH_INT;
					int_rx  = RX_DEC;
					do_int  = 1'b1;
				end
			end
		endcase

		int_marker = (int_rx == RX_HEX) ? CH_UP_P : CH_UP_E;

		if (do_int && !quote) begin
			if (int_rx == RX_OCT) begin
				if (d < 5'd10) begin
					if (d < 5'd8) begin
						main_n = mul_radix(cur_main, RX_OCT) + acc_digit(d);
					end else begin
						n.octal_bad = 1'b1;
					end
					alt_n = mul_radix(cur_alt, RX_DEC) + acc_digit(d);
				end else if (c == CH_DOT || c == CH_UP_E) begin
					// turns out decimal after a leading zero
					n.radix = RX_DEC;
					main_n  = cur_alt;
					n.phase = (c == CH_DOT) ? PH_FRAC : PH_EXP_SIGN;
				end else begin
					n.bad_char = 1'b1;
				end
			end else if (c == int_marker) begin
				n.phase = PH_EXP_SIGN;
			end else if (c == CH_DOT) begin
				n.phase = PH_FRAC;
			end else if (d < radix_value(int_rx)) begin
				main_n = mul_radix(cur_main, int_rx) + acc_digit(d);
			end else begin
				n.bad_char = 1'b1;
			end
		end

		is_exp            = (n.phase == PH_EXP_SIGN) || (n.phase == PH_EXP);
		kind              = is_exp ? KIND_EXP : ((n.phase == PH_FRAC) ? KIND_FRAC : KIND_INT);
		radix_code        = n.radix;
		numerator         = main_n;
		denominator       = scale_n;
		exponent          = is_exp ? exp_n : '0;
		exponent_base_two = is_exp && (n.radix == RX_HEX);
		exponent_negative = is_exp && n.exp_minus;
		error             = n.bad_char || (n.radix == RX_OCT && n.octal_bad);

		// back to the start of a literal after its last character
		if (last) begin
			nxt_ctl   = CTL_RESET;
			nxt_main  = '0;
			nxt_alt   = '0;
			nxt_scale = ACC_ONE;
			nxt_exp   = '0;
		end else begin
			nxt_ctl   = n;
			nxt_main  = main_n;
			nxt_alt   = alt_n;
			nxt_scale = scale_n;
			nxt_exp   = exp_n;
		end
	end
endmodule

// File: sv/nlp_out_reg.sv
// ----------------------------------------------------------------------------
// nlp_out_reg
// result register toward the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_out_reg #(
	parameter int unsigned ACC_WIDTH = nlp_pkg::ACC_WIDTH_DEF,
	parameter int unsigned EXP_WIDTH = nlp_pkg::EXP_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [1:0]           kind,
	input  logic [1:0]           radix_code,
	input  logic [ACC_WIDTH-1:0] numerator,
	input  logic [ACC_WIDTH-1:0] denominator,
	input  logic [EXP_WIDTH-1:0] exponent,
	input  logic                 exponent_base_two,
	input  logic                 exponent_negative,
	input  logic                 error,
	output logic                 stall,
	nlp_out_if.source            result
);
	logic                 valid_q;
	logic [1:0]           kind_q;
	logic [1:0]           radix_q;
	logic [ACC_WIDTH-1:0] num_q;
	logic [ACC_WIDTH-1:0] den_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic                 base_two_q;
	logic                 negative_q;
	logic                 error_q;

	assign stall = valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q     <= kind;
			radix_q    <= radix_code;
			num_q      <= numerator;
			den_q      <= denominator;
			exp_q      <= exponent;
			base_two_q <= exponent_base_two;
			negative_q <= exponent_negative;
			error_q    <= error;
		end
	end

	assign result.valid             = valid_q;
	assign result.kind              = kind_q;
	assign result.radix_code        = radix_q;
	assign result.numerator         = num_q;
	assign result.denominator       = den_q;
	assign result.exponent          = exp_q;
	assign result.exponent_base_two = base_two_q;
	assign result.exponent_negative = negative_q;
	assign result.error             = error_q;
endmodule

// File: sv/numeric_literal_parser_core.sv
// ----------------------------------------------------------------------------
// numeric_literal_parser_core
// Parses a C++ numeric literal one character per request and returns its
// kind, radix, numerator, denominator and exponent with an error flag when
// the request marked last is processed. One character is taken every clock
// cycle unless a last character waits on a stalled result. A character is
// parsed in the input register; the parser state and, for a last character,
// the result register load when it advances. The parser state update (one
// shift-and-add per accumulator) sets the rate of one character per cycle
// while nothing stalls. The result register lets further characters flow
// while a result waits. Only a last character is held in the input register,
// and only while the previous result is still unaccepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module numeric_literal_parser_core #(
	parameter int unsigned ACC_WIDTH = nlp_pkg::ACC_WIDTH_DEF,
	parameter int unsigned EXP_WIDTH = nlp_pkg::EXP_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	nlp_in_if.sink    chars,
	nlp_out_if.source result
);
	import nlp_pkg::*;

	localparam logic [ACC_WIDTH-1:0] ACC_ONE = {{(ACC_WIDTH-1){1'b0}}, 1'b1};

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 last_s1;
	logic                 advance;
	logic                 out_stall;

	ctl_t                 ctl_q;
	logic [ACC_WIDTH-1:0] main_q;
	logic [ACC_WIDTH-1:0] alt_q;
	logic [ACC_WIDTH-1:0] scale_q;
	logic [EXP_WIDTH-1:0] exp_q;

	ctl_t                 nxt_ctl;
	logic [ACC_WIDTH-1:0] nxt_main;
	logic [ACC_WIDTH-1:0] nxt_alt;
	logic [ACC_WIDTH-1:0] nxt_scale;
	logic [EXP_WIDTH-1:0] nxt_exp;

	logic [1:0]           res_kind;
	logic [1:0]           res_radix;
	logic [ACC_WIDTH-1:0] res_num;
	logic [ACC_WIDTH-1:0] res_den;
	logic [EXP_WIDTH-1:0] res_exp;
	logic                 res_base_two;
	logic                 res_negative;
	logic                 res_error;

	// a non-final character never needs the result register
	assign advance = valid_s1 && (!last_s1 || !out_stall);

	nlp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.ch_s1    (ch_s1),
		.last_s1  (last_s1)
	);

	nlp_step #(
		.ACC_WIDTH (ACC_WIDTH),
		.EXP_WIDTH (EXP_WIDTH)
	) u_step (
		.ch                (ch_s1),
		.last              (last_s1),
		.cur_ctl           (ctl_q),
		.cur_main          (main_q),
		.cur_alt           (alt_q),
		.cur_scale         (scale_q),
		.cur_exp           (exp_q),
		.nxt_ctl           (nxt_ctl),
		.nxt_main          (nxt_main),
		.nxt_alt           (nxt_alt),
		.nxt_scale         (nxt_scale),
		.nxt_exp           (nxt_exp),
		.kind              (res_kind),
		.radix_code        (res_radix),
		.numerator         (res_num),
		.denominator       (res_den),
		.exponent          (res_exp),
		.exponent_base_two (res_base_two),
		.exponent_negative (res_negative),
		.error             (res_error)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= CTL_RESET;
			main_q  <= '0;
			alt_q   <= '0;
			scale_q <= ACC_ONE;
			exp_q   <= '0;
		end else if (advance) begin
			ctl_q   <= nxt_ctl;
			main_q  <= nxt_main;
			alt_q   <= nxt_alt;
			scale_q <= nxt_scale;
			exp_q   <= nxt_exp;
		end
	end

	nlp_out_reg #(
		.ACC_WIDTH (ACC_WIDTH),
		.EXP_WIDTH (EXP_WIDTH)
	) u_out_reg (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (advance && last_s1),
		.kind              (res_kind),
		.radix_code        (res_radix),
		.numerator         (res_num),
		.denominator       (res_den),
		.exponent          (res_exp),
		.exponent_base_two (res_base_two),
		.exponent_negative (res_negative),
		.error             (res_error),
		.stall             (out_stall),
		.result            (result)
	);
endmodule

// File: sv/nlp_checker.sv
// ----------------------------------------------------------------------------
// nlp_checker
// port-level checks on the parser result channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "numeric_literal_parser_core_defines.svh"

module nlp_checker #(
	parameter int unsigned ACC_WIDTH = nlp_pkg::ACC_WIDTH_DEF,
	parameter int unsigned EXP_WIDTH = nlp_pkg::EXP_WIDTH_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [1:0]           res_kind,
	input logic [1:0]           res_radix,
	input logic [ACC_WIDTH-1:0] res_num,
	input logic [ACC_WIDTH-1:0] res_den,
	input logic [EXP_WIDTH-1:0] res_exp,
	input logic                 res_base_two,
	input logic                 res_negative
);
	import nlp_pkg::*;

	localparam logic [ACC_WIDTH-1:0] ACC_ONE = {{(ACC_WIDTH-1){1'b0}}, 1'b1};

	`NLP_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(res_num), "stalled result changed")
	`NLP_ASSERT_SAME(a_no_exp_fields, res_valid && res_kind != KIND_EXP, res_exp == '0 && !res_base_two && !res_negative, "exponent fields set without exponent")
	`NLP_ASSERT_SAME(a_int_denominator, res_valid && res_kind == KIND_INT, res_den == ACC_ONE, "integer result with denominator not one")
	`NLP_ASSERT_SAME(a_base_two_hex, res_valid && res_base_two, res_radix == RX_HEX, "base two exponent outside hexadecimal")
endmodule

bind numeric_literal_parser_core nlp_checker #(
	.ACC_WIDTH (ACC_WIDTH),
	.EXP_WIDTH (EXP_WIDTH)
) u_nlp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_kind     (result.kind),
	.res_radix    (result.radix_code),
	.res_num      (result.numerator),
	.res_den      (result.denominator),
	.res_exp      (result.exponent),
	.res_base_two (result.exponent_base_two),
	.res_negative (result.exponent_negative)
);
